/* hdl/decimal_integer_token_parser_defines.svh */
// Assertion macros for the decimal integer token parser checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef DECIMAL_INTEGER_TOKEN_PARSER_DEFINES_SVH
`define DECIMAL_INTEGER_TOKEN_PARSER_DEFINES_SVH

// check on every clock edge outside reset
`define DIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define DIT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dit_pkg.sv */
// Shared types and constants of the decimal integer token parser.
// Depends on nothing.
package dit_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAG_PORT_W     = 64;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 8;
  localparam int OQ_DEPTH       = 8;
  localparam int OQ_PTR_W       = $clog2(OQ_DEPTH);
  localparam int OQ_LEVEL_W     = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED = CFG_INDEX_W'(1);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_DIGIT_EXPECTED = 2'd1,
    ST_OVERFLOW       = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    neg;
  } res_tag_t;

  typedef struct packed {
    logic [1:0] count;
    res_tag_t   tag0;
    res_tag_t   tag1;
  } push_t;

endpackage

/* hdl/dit_regs.sv */
// Configuration registers: magnitude limit and signed mode.
// Depends on dit_pkg; keeps the positive and the negative limit ready.
module dit_regs import dit_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [VALUE_BITS-1:0]  lim_pos,
  output logic [VALUE_BITS-1:0]  lim_neg,
  output logic                   signed_mode
);

  logic [VALUE_BITS-1:0] lim_pos_r, lim_pos_nxt;
  logic [VALUE_BITS-1:0] lim_neg_r, lim_neg_nxt;
  logic                  signed_r, signed_nxt;
  logic [VALUE_BITS-1:0] wr_lim;

  assign cfg_ready = 1'b1;
  assign wr_lim    = cfg_data[VALUE_BITS-1:0];

  always_comb begin
    lim_pos_nxt = lim_pos_r;
    lim_neg_nxt = lim_neg_r;
    signed_nxt  = signed_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIMIT: begin
          lim_pos_nxt = wr_lim;
          // saturate the negative limit at all ones
          lim_neg_nxt = (&wr_lim) ? wr_lim : wr_lim + VALUE_BITS'(1);
        end
        REG_SIGNED: signed_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_pos_r <= '1;
      lim_neg_r <= '1;
      signed_r  <= 1'b0;
    end else begin
      lim_pos_r <= lim_pos_nxt;
      lim_neg_r <= lim_neg_nxt;
      signed_r  <= signed_nxt;
    end
  end

  assign lim_pos     = lim_pos_r;
  assign lim_neg     = lim_neg_r;
  assign signed_mode = signed_r;

endmodule

/* hdl/dit_core.sv */
// Parser core: input register, token state and the one-pass step logic.
// Depends on dit_pkg; pushes up to two results per byte into dit_outq.
module dit_core import dit_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_eoi,
  input  logic [VALUE_BITS-1:0] lim_pos,
  input  logic [VALUE_BITS-1:0] lim_neg,
  input  logic                  signed_mode,
  input  logic [OQ_LEVEL_W-1:0] level,
  output push_t                 push,
  output logic [VALUE_BITS-1:0] push_mag
);

  localparam int SW = VALUE_BITS + 4;

  logic                  stage_v_r;
  logic [7:0]            byte_r;
  logic                  eoi_r;

  logic                  in_num_r, in_num_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  dseen_r, dseen_nxt;
  logic                  neg_r, neg_nxt;

  logic [OQ_LEVEL_W:0]   need;
  logic                  is_digit, is_space, is_minus;
  logic [SW-1:0]         sum;
  logic [VALUE_BITS-1:0] lim_act;
  logic                  ovf;
  push_t                 push_c;
  logic [VALUE_BITS-1:0] mag_c;

  assign need     = {1'b0, level} + (stage_v_r ? (OQ_LEVEL_W+1)'(2) : '0);
  assign in_ready = need <= (OQ_LEVEL_W+1)'(OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      eoi_r  <= in_eoi;
    end
  end

  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
  assign is_space = (byte_r == CH_SPACE) || ((byte_r >= CH_TAB) && (byte_r <= CH_CR));
  assign is_minus = (byte_r == CH_MINUS) && signed_mode;

  // accumulator * 10 + digit, against the limit for the current sign
  assign sum     = (SW'(acc_r) << 3) + (SW'(acc_r) << 1) + SW'(byte_r[3:0]);
  assign lim_act = neg_r ? lim_neg : lim_pos;
  assign ovf     = sum > SW'(lim_act);

  always_comb begin
    logic reexam;
    reexam      = 1'b0;
    in_num_nxt  = in_num_r;
    acc_nxt     = acc_r;
    dseen_nxt   = dseen_r;
    neg_nxt     = neg_r;
    push_c      = '0;
    push_c.tag0 = '{status: ST_OK, neg: 1'b0};
    push_c.tag1 = '{status: ST_OK, neg: 1'b0};
    mag_c       = '0;
    if (eoi_r) begin
      push_c.count = 2'd1;
      if (in_num_r && dseen_r) begin
        push_c.tag0 = '{status: ST_OK, neg: neg_r && (acc_r != '0)};
        mag_c       = acc_r;
      end else begin
        push_c.tag0.status = ST_DIGIT_EXPECTED;
      end
      in_num_nxt = 1'b0;
      acc_nxt    = '0;
      dseen_nxt  = 1'b0;
      neg_nxt    = 1'b0;
    end else begin
      reexam = !in_num_r;
      if (in_num_r) begin
        if (is_digit) begin
          if (ovf) begin
            push_c.count       = 2'd1;
            push_c.tag0.status = ST_OVERFLOW;
            in_num_nxt         = 1'b0;
            acc_nxt            = '0;
            dseen_nxt          = 1'b0;
            neg_nxt            = 1'b0;
          end else begin
            acc_nxt   = sum[VALUE_BITS-1:0];
            dseen_nxt = 1'b1;
          end
        end else begin
          push_c.count = 2'd1;
          in_num_nxt   = 1'b0;
          acc_nxt      = '0;
          dseen_nxt    = 1'b0;
          neg_nxt      = 1'b0;
          if (!dseen_r) begin
            push_c.tag0.status = ST_DIGIT_EXPECTED;
          end else begin
            push_c.tag0 = '{status: ST_OK, neg: neg_r && (acc_r != '0)};
            mag_c       = acc_r;
            reexam      = 1'b1;
          end
        end
      end
      // delimiter or fresh byte seen from the seeking state
      if (reexam) begin
        if (is_space) begin
          in_num_nxt = 1'b0;
        end else if (is_minus) begin
          in_num_nxt = 1'b1;
          neg_nxt    = 1'b1;
        end else if (is_digit) begin
          if (ovf) begin
            push_c.count       = 2'd1;
            push_c.tag0.status = ST_OVERFLOW;
          end else begin
            in_num_nxt = 1'b1;
            acc_nxt    = sum[VALUE_BITS-1:0];
            dseen_nxt  = 1'b1;
          end
        end else if (in_num_r) begin
          push_c.count       = 2'd2;
          push_c.tag1.status = ST_DIGIT_EXPECTED;
        end else begin
          push_c.count       = 2'd1;
          push_c.tag0.status = ST_DIGIT_EXPECTED;
        end
      end
    end
    if (!stage_v_r) begin
      push_c.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_num_r <= 1'b0;
      acc_r    <= '0;
      dseen_r  <= 1'b0;
      neg_r    <= 1'b0;
    end else if (stage_v_r) begin
      in_num_r <= in_num_nxt;
      acc_r    <= acc_nxt;
      dseen_r  <= dseen_nxt;
      neg_r    <= neg_nxt;
    end
  end

  assign push     = push_c;
  assign push_mag = mag_c;

endmodule

/* hdl/dit_outq.sv */
// Result queue: takes up to two results a cycle, hands out one while out_ready is high.
// Depends on dit_pkg; fed by dit_core, drives the master-side stream.
module dit_outq import dit_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  push_t                 push,
  input  logic [VALUE_BITS-1:0] push_mag,
  output logic [OQ_LEVEL_W-1:0] level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output res_tag_t              out_tag,
  output logic [VALUE_BITS-1:0] out_mag
);

  localparam int EW = VALUE_BITS + $bits(res_tag_t);

  function automatic logic [OQ_PTR_W-1:0] inc(input logic [OQ_PTR_W-1:0] p);
    return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
  endfunction

  logic [EW-1:0]         mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_LEVEL_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wr_ptr1;

  assign pop     = out_valid && out_ready;
  assign wr_ptr1 = inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + OQ_LEVEL_W'(push.count) - OQ_LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= {push.tag0, push_mag};
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr1] <= {push.tag1, VALUE_BITS'(0)};
    end
  end

  assign level     = cnt_r;
  assign out_valid = cnt_r != '0;
  assign out_tag   = mem_r[rd_ptr_r][EW-1:VALUE_BITS];
  assign out_mag   = mem_r[rd_ptr_r][VALUE_BITS-1:0];

endmodule

/* hdl/decimal_integer_token_parser.sv */
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tdata: in_byte; tlast: end_of_input
// out_     out  out_tvalid/tready  tdata: magnitude; tuser: status, is_negative
// cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
// One byte per cycle while in_tready is high; an accepted byte is held in the input
// register, and the step logic between it and the eight-entry result queue writes
// its results into the queue; a byte may leave two results, queued in the same cycle.
// in_tready drops while the queue, the byte in flight and a new byte could exceed eight entries.
// rst_n is synchronous: it clears the token state and queue, restores config.
// Top level: config registers, parser core and result queue.
// Depends on dit_pkg, dit_regs, dit_core and dit_outq.
module decimal_integer_token_parser import dit_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] in_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [MAG_PORT_W-1:0]  out_tdata,  // [63:0] magnitude
  output logic [2:0]             out_tuser,  // [1:0] status, [2] is_negative
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [VALUE_BITS-1:0] lim_pos;
  logic [VALUE_BITS-1:0] lim_neg;
  logic                  signed_mode;
  logic [OQ_LEVEL_W-1:0] level;
  push_t                 push;
  logic [VALUE_BITS-1:0] push_mag;
  res_tag_t              out_tag;
  logic [VALUE_BITS-1:0] out_mag;

  dit_regs #(.VALUE_BITS(VALUE_BITS)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .lim_pos     (lim_pos),
    .lim_neg     (lim_neg),
    .signed_mode (signed_mode)
  );

  dit_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .in_eoi      (in_tlast),
    .lim_pos     (lim_pos),
    .lim_neg     (lim_neg),
    .signed_mode (signed_mode),
    .level       (level),
    .push        (push),
    .push_mag    (push_mag)
  );

  dit_outq #(.VALUE_BITS(VALUE_BITS)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_mag  (push_mag),
    .level     (level),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tag   (out_tag),
    .out_mag   (out_mag)
  );

  assign out_tdata = MAG_PORT_W'(out_mag);
  assign out_tuser = {out_tag.neg, out_tag.status};

endmodule

/* hdl/dit_checker.sv */
// Port-level checks on the result stream of the token parser.
// Depends on dit_pkg and the defines header; bound to the top level.
`include "decimal_integer_token_parser_defines.svh"

module dit_checker import dit_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [MAG_PORT_W-1:0] out_tdata,
  input logic [2:0]            out_tuser
);

  `DIT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `DIT_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `DIT_ASSERT(a_err_clean, out_tvalid && out_tuser[1:0] != ST_OK |-> out_tdata == '0 && !out_tuser[2], "error result carries a value")
  `DIT_ASSERT(a_neg_nonzero, out_tvalid && out_tuser[2] |-> out_tdata != '0 && out_tuser[1:0] == ST_OK, "negative zero or negative error")

endmodule

bind decimal_integer_token_parser dit_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* bench/decimal_integer_token_parser_tb.sv */
// Testbench for decimal_integer_token_parser: directed and random text streams
// checked against an in-bench token predictor. Depends on dit_pkg and the RTL.
`timescale 1ns / 100ps

module decimal_integer_token_parser_tb import dit_pkg::*; ();

  localparam logic [63:0] ALL_ONES = '1;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    status_t     status;
    logic [63:0] mag;
    logic        neg;
  } token_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [MAG_PORT_W-1:0]  out_tdata;
  logic [2:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state and configuration copy
  logic [63:0] lim_reg = ALL_ONES;
  logic        signed_en = 1'b0;
  logic        tok_active = 1'b0;
  logic [63:0] acc = '0;
  logic        saw_digit = 1'b0;
  logic        neg_sign = 1'b0;

  token_res_t parsed_q[$];
  char_req_t  char_q[$];

  int  err_cnt = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  tx_live = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;

  decimal_integer_token_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void seek_token();
    tok_active = 1'b0;
    acc = '0;
    saw_digit = 1'b0;
    neg_sign = 1'b0;
  endfunction

  function automatic void post_result(status_t st, logic [63:0] m, logic ng);
    token_res_t r;
    r.status = st;
    r.mag = (st == ST_OK) ? m : 64'd0;
    r.neg = (st == ST_OK) && (m != 64'd0) && ng;
    parsed_q.push_back(r);
  endfunction

  function automatic bit accept_digit(logic [63:0] d);
    logic [63:0] lim;
    lim = lim_reg;
    if (neg_sign && lim != ALL_ONES) lim = lim + 64'd1;
    if (acc > lim / 64'd10 || d > lim - 64'd10 * acc) return 1'b0;
    acc = acc * 64'd10 + d;
    saw_digit = 1'b1;
    return 1'b1;
  endfunction

  function automatic void parse_char(logic [7:0] c, logic eoi);
    logic        dig;
    logic        ws;
    logic [63:0] d;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    d = 64'(c - CH_ZERO);
    if (eoi) begin
      if (tok_active && saw_digit) post_result(ST_OK, acc, neg_sign);
      else post_result(ST_DIGIT_EXPECTED, 64'd0, 1'b0);
      seek_token();
      return;
    end
    if (tok_active) begin
      if (dig) begin
        if (!accept_digit(d)) begin
          post_result(ST_OVERFLOW, 64'd0, 1'b0);
          seek_token();
        end
        return;
      end
      if (!saw_digit) begin
        post_result(ST_DIGIT_EXPECTED, 64'd0, 1'b0);
        seek_token();
        return;
      end
      // close the number, then examine the delimiter again
      post_result(ST_OK, acc, neg_sign);
      seek_token();
    end
    if (ws) return;
    if (c == CH_MINUS && signed_en) begin
      tok_active = 1'b1;
      neg_sign = 1'b1;
      return;
    end
    if (dig) begin
      tok_active = 1'b1;
      if (!accept_digit(d)) begin
        post_result(ST_OVERFLOW, 64'd0, 1'b0);
        seek_token();
      end
      return;
    end
    post_result(ST_DIGIT_EXPECTED, 64'd0, 1'b0);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch %s: want %0h got %0h", what, want, got);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    token_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_q.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, out_tdata);
      end else begin
        want = parsed_q.pop_front();
        if (out_tuser[1:0] !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_tuser[1:0]));
        if (out_tdata !== want.mag) report_mismatch("magnitude", want.mag, out_tdata);
        if (out_tuser[2] !== want.neg)
          report_mismatch("is_negative", 64'(want.neg), 64'(out_tuser[2]));
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic eoi);
    int gap;
    if (tx_live && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eoi;
    tx_live = 1'b1;
    do @(posedge clk); while (!in_tready);
    parse_char(b, eoi);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_idle();
    if (tx_live) in_tvalid <= 1'b0;
    tx_live = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [63:0] lim, logic sgn);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LIMIT;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    lim_reg = lim;
    cfg_index <= REG_SIGNED;
    cfg_data <= CFG_DATA_W'(sgn);
    do @(posedge clk); while (!cfg_ready);
    signed_en = sgn;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_space();
    if ($urandom_range(6) == 6) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(4));
  endfunction

  function automatic void queue_token();
    int          kind;
    int          variant;
    string       s;
    logic [63:0] v;
    char_req_t   cr;
    kind = $urandom_range(99);
    cr.eoi = 1'b0;
    if (kind < 75) begin
      if (signed_en ? ($urandom_range(2) != 0) : ($urandom_range(9) == 0)) begin
        cr.ch = CH_MINUS;
        char_q.push_back(cr);
      end
      case ($urandom_range(3))
        0: s = $sformatf("%0d", $urandom_range(999));
        1: begin
          v = {$urandom, $urandom} >> $urandom_range(63);
          s = $sformatf("%0d", v);
        end
        2: s = $sformatf("%0d", lim_reg);
        default: s = {"00", $sformatf("%0d", $urandom_range(99))};
      endcase
      for (int i = 0; i < s.len(); i++) begin
        cr.ch = s[i];
        char_q.push_back(cr);
      end
      variant = $urandom_range(3);
      if (variant == 1) begin
        char_q[char_q.size() - 1].ch = CH_ZERO + 8'($urandom_range(9));
      end else if (variant == 2) begin
        cr.ch = CH_ZERO + 8'($urandom_range(9));
        char_q.push_back(cr);
      end else if (variant == 3 && s.len() > 1) begin
        void'(char_q.pop_back());
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          cr.ch = pick_space();
          char_q.push_back(cr);
        end
        5, 6: begin
          cr.ch = 8'($urandom_range(255));
          char_q.push_back(cr);
        end
        7: begin
          cr.ch = 8'($urandom_range(255));
          cr.eoi = 1'b1;
          char_q.push_back(cr);
        end
        default: ;
      endcase
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) begin
        cr.ch = 8'($urandom_range(255));
        char_q.push_back(cr);
      end
    end else if (kind < 95) begin
      cr.ch = CH_MINUS;
      char_q.push_back(cr);
      cr.ch = ($urandom_range(1) == 0) ? pick_space() : 8'($urandom_range(255));
      cr.eoi = 1'($urandom_range(1));
      char_q.push_back(cr);
    end else begin
      cr.ch = 8'($urandom_range(255));
      cr.eoi = 1'b1;
      char_q.push_back(cr);
    end
  endfunction

  task automatic random_burst(int n_items);
    int        cnt;
    char_req_t cr;
    cnt = 0;
    while (cnt < n_items) begin
      queue_token();
      while (char_q.size() != 0) begin
        cr = char_q.pop_front();
        send_item(cr.ch, cr.eoi);
        if (cr.eoi || !(cr.ch == CH_SPACE || (cr.ch >= CH_TAB && cr.ch <= CH_CR))) cnt++;
      end
    end
  endtask

  task automatic test_unsigned_basics();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text(" 12-0");
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);
    wait_idle();
  endtask

  task automatic test_signed_limits();
    write_regs(64'd127, 1'b1);
    send_text("-128 -129 128 -\n-0,-");
    send_item(CH_SPACE, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(ALL_ONES, 1'b0);
    hold_req = 1'b1;
    repeat (30) send_text("7x");
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [63:0] lim;
    logic        sgn;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin lim = ALL_ONES; sgn = 1'b0; end
        1: begin lim = ALL_ONES; sgn = 1'b1; end
        2: begin lim = 64'd0; sgn = 1'b1; end
        3: begin lim = 64'd1; sgn = 1'b0; end
        4: begin lim = {$urandom, $urandom}; sgn = 1'b1; end
        5: begin lim = 64'($urandom_range(1, 100000)); sgn = 1'b1; end
        default: begin lim = 64'd10; sgn = 1'b0; end
      endcase
      if (ph < 3) begin
        tx_idle_pct = 9;
        rx_idle_pct = 66;
      end else if (ph < 5) begin
        tx_idle_pct = 66;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_regs(lim, sgn);
      random_burst(230);
      wait_idle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 9;
    rx_idle_pct = 66;
    test_unsigned_basics();
    test_signed_limits();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
